### design/bsp_pkg.sv
// Shared types, constants and helpers for the billboard sprite projector.
package bsp_pkg;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCALE_HORIZ   = 3'd2;
    localparam logic [2:0] REG_SCALE_VERT    = 3'd3;
    localparam logic [2:0] REG_VERT_OFFSET   = 3'd4;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [15:0] scale_h;
        logic [15:0] scale_v;
        logic [15:0] voff;
    } cfg_t;

    // Sine of a heading step, rounded into the coordinate fraction format.
    // Elaboration-time and table use only: every caller passes a constant index.
    function automatic logic signed [31:0] sine_fx(input int idx, input int hbits,
                                                   input int fbits);
        logic [63:0] n, quarter, q, r, theta, t2, term, sum, val;
        int k;
        n = 64'd1 << hbits;
        quarter = n >> 2;
        q = (64'(idx) & (n - 64'd1)) >> (hbits - 2);
        r = 64'(idx) & (quarter - 64'd1);
        if (q[0])
            r = quarter - r;
        theta = (r * TWO_PI_Q30 + (64'd1 << (hbits - 1))) >> hbits;
        t2 = (theta * theta) >> 30;
        term = theta;
        sum = theta;
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        val = ((sum << fbits) + (64'd1 << 29)) >> 30;
        return (q >= 64'd2) ? -32'(val) : 32'(val);
    endfunction

endpackage

### design/billboard_sprite_projector.sv
// Top level of the billboard sprite projector pipeline.
//
//  channel   signals                                  direction  transaction when
//  command   start, busy, object/viewer fields        in         start && !busy
//  result    done, distance_squared .. behind_viewer  out        every cycle done is high
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid && cfg_ready
//
// One command is taken every cycle; busy is tied low because the receiver never
// stalls. From the accepting edge to the edge that raises done, a command passes the
// front stages, then the three parallel one-bit-per-stage divider chains (size,
// vertical shift, centre column), CNW stages each, then the output stages.
// Reset clears the valid bits and loads the register defaults; data carries none.
// Configuration captured with each command travels down the pipe beside it.
module billboard_sprite_projector
    import bsp_pkg::*;
#(
    parameter int HEADING_BITS  = 10,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      object_x,
    input  logic signed [15:0]      object_y,
    input  logic signed [15:0]      viewer_x,
    input  logic signed [15:0]      viewer_y,
    input  logic [HEADING_BITS-1:0] viewer_heading,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    output logic                    done,
    output logic [32:0]             distance_squared,
    output logic signed [15:0]      centre_column,
    output logic [14:0]             sprite_height,
    output logic [14:0]             sprite_width,
    output logic [14:0]             top_row,
    output logic signed [15:0]      bottom_row,
    output logic [14:0]             left_column,
    output logic signed [15:0]      right_column,
    output logic                    behind_viewer
);
    localparam int HN   = 1 << HEADING_BITS;
    localparam int QTR  = HN / 4;
    localparam int TRW  = FRACTION_BITS + 2;          // sine magnitude bits, signed
    localparam int TYW  = 17 + TRW + 1;               // tx/ty width
    localparam int VQW  = 16 + FRACTION_BITS;         // |voff| << F
    localparam int CNW  = 12 + TYW;                   // |half_w*(ty+tx)|

    cfg_t cfg_reg;
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width   <= 13'd640;
            cfg_reg.height  <= 13'd480;
            cfg_reg.scale_h <= 16'd256;
            cfg_reg.scale_v <= 16'd256;
            cfg_reg.voff    <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.width   <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: cfg_reg.height  <= cfg_data[12:0];
                REG_SCALE_HORIZ:   cfg_reg.scale_h <= cfg_data;
                REG_SCALE_VERT:    cfg_reg.scale_v <= cfg_data;
                REG_VERT_OFFSET:   cfg_reg.voff    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sine table, built at elaboration.
    logic signed [TRW-1:0] sin_tab [HN];
    for (genvar g = 0; g < HN; g++)
    begin : g_tab
        assign sin_tab[g] = TRW'(sine_fx(g, HEADING_BITS, FRACTION_BITS));
    end

    // Stage 1: offsets, table look-up.
    logic [2:0]            v_reg;
    logic signed [16:0]    dx_reg, dy_reg;
    logic signed [TRW-1:0] s_reg, c_reg;
    cfg_t                  c1_reg, c2_reg, c3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], start && !busy};
    end
    always_ff @(posedge clk)
    begin
        dx_reg <= 17'(object_x) - 17'(viewer_x);
        dy_reg <= 17'(object_y) - 17'(viewer_y);
        s_reg  <= sin_tab[viewer_heading];
        c_reg  <= sin_tab[HEADING_BITS'(viewer_heading + HEADING_BITS'(QTR))];
        c1_reg <= cfg_reg;
    end

    // Stage 2: products.
    logic signed [TYW-1:0] sdx_reg, cdy_reg, cdx_reg, sdy_reg;
    logic [32:0]           dxx_reg, dyy_reg;
    always_ff @(posedge clk)
    begin
        sdx_reg <= TYW'(s_reg * dx_reg);
        cdy_reg <= TYW'(c_reg * dy_reg);
        cdx_reg <= TYW'(c_reg * dx_reg);
        sdy_reg <= TYW'(s_reg * dy_reg);
        dxx_reg <= 33'($unsigned(34'(dx_reg) * 34'(dx_reg)));
        dyy_reg <= 33'($unsigned(34'(dy_reg) * 34'(dy_reg)));
        c2_reg  <= c1_reg;
    end

    // Stage 3: tx, ty, distance.
    logic signed [TYW-1:0] tx_reg, ty_reg;
    logic [32:0]           dist_reg;
    always_ff @(posedge clk)
    begin
        tx_reg   <= sdx_reg - cdy_reg;
        ty_reg   <= cdx_reg + sdy_reg;
        dist_reg <= dxx_reg + dyy_reg;
        c3_reg   <= c2_reg;
    end

    // Stage 4: divider operands. Centre numerator product registered here.
    logic                  v4_reg;
    logic [TYW-1:0]        den_reg;
    logic signed [CNW:0]   cnum_reg;
    logic [VQW-1:0]        vnum_reg;
    logic                  vneg_reg, behind_reg;
    logic [32:0]           dist4_reg;
    cfg_t                  c4_reg;
    logic signed [TYW:0]   typtx;
    assign typtx = (TYW+1)'(ty_reg) + (TYW+1)'(tx_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v_reg[2];
    end
    always_ff @(posedge clk)
    begin
        den_reg    <= $unsigned(ty_reg);
        behind_reg <= (ty_reg <= 0);
        cnum_reg   <= (CNW+1)'($signed({1'b0, c3_reg.width[12:1]})) * (CNW+1)'(typtx);
        vneg_reg   <= c3_reg.voff[15];
        vnum_reg   <= VQW'($unsigned(c3_reg.voff[15] ? -17'($signed(c3_reg.voff))
                                                     : 17'($signed(c3_reg.voff))))
                      << FRACTION_BITS;
        dist4_reg  <= dist_reg;
        c4_reg     <= c3_reg;
    end

    // Stage 5: sign/magnitude of centre numerator.
    logic                 v5_reg, cneg_reg, behind5_reg, vneg5_reg;
    logic [CNW-1:0]       cmag_reg;
    logic [TYW-1:0]       den5_reg;
    logic [VQW-1:0]       vnum5_reg;
    logic [32:0]          dist5_reg;
    cfg_t                 c5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        cneg_reg    <= cnum_reg[CNW];
        cmag_reg    <= CNW'(cnum_reg[CNW] ? -cnum_reg : cnum_reg);
        den5_reg    <= behind_reg ? TYW'(1) : den_reg;
        behind5_reg <= behind_reg;
        vneg5_reg   <= vneg_reg;
        vnum5_reg   <= vnum_reg;
        dist5_reg   <= dist4_reg;
        c5_reg      <= c4_reg;
    end

    // Dividers: all padded to the same length so the results line up.
    localparam int TAGW = 33 + 1 + 1 + 1 + $bits(cfg_t);
    logic [CNW-1:0] cq, bq, vq;
    logic [TAGW-1:0] tag_in, tag_out;
    logic dv, bv_unused, vv_unused;
    logic [CNW-1:0] bnum, vnum;
    logic [TAGW-1:0] t_b, t_v;
    assign tag_in = {dist5_reg, behind5_reg, cneg_reg, vneg5_reg, c5_reg};
    assign bnum   = CNW'({c5_reg.height, (2*FRACTION_BITS)'(0)});
    assign vnum   = CNW'(vnum5_reg);

    bsp_divider #(.NW(CNW), .DW(TYW), .TW(TAGW)) u_div_c
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg), .num(cmag_reg), .den(den5_reg),
        .tag(tag_in), .out_valid(dv), .quo(cq), .out_tag(tag_out)
    );
    bsp_divider #(.NW(CNW), .DW(TYW), .TW(TAGW)) u_div_b
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg), .num(bnum), .den(den5_reg),
        .tag(tag_in), .out_valid(bv_unused), .quo(bq), .out_tag(t_b)
    );
    bsp_divider #(.NW(CNW), .DW(TYW), .TW(TAGW)) u_div_v
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg), .num(vnum), .den(den5_reg),
        .tag(tag_in), .out_valid(vv_unused), .quo(vq), .out_tag(t_v)
    );

    logic [32:0] dist6;
    logic        behind6, cneg6, vneg6;
    cfg_t        c6;
    assign {dist6, behind6, cneg6, vneg6, c6} = tag_out;

    // Stage 6: signed centre (saturated), clamped base, vertical shift.
    logic                v6_reg, b6_reg;
    logic signed [15:0]  cen6_reg;
    logic [32:0]         base6_reg;
    logic signed [VQW:0] voq6_reg;
    logic [32:0]         d6_reg;
    cfg_t                k6_reg;
    logic signed [CNW:0] csig;
    logic signed [VQW:0] vsig;
    always_comb
    begin
        csig = cneg6 ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
        vsig = vneg6 ? -$signed({1'b0, vq[VQW-1:0]}) : $signed({1'b0, vq[VQW-1:0]});
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        b6_reg    <= behind6;
        cen6_reg  <= (csig > 32767) ? 16'sd32767 : (csig < -32768) ? -16'sd32768 : 16'(csig);
        base6_reg <= (bq > CNW'(64'h1_0000_0000)) ? 33'h1_0000_0000 : 33'(bq);
        voq6_reg  <= vsig;
        d6_reg    <= dist6;
        k6_reg    <= c6;
    end

    // Stage 7: scaled sizes.
    logic                v7_reg, b7_reg;
    logic signed [15:0]  cen7_reg;
    logic [48:0]         hp7_reg, wp7_reg;
    logic signed [VQW:0] voq7_reg;
    logic [32:0]         d7_reg;
    cfg_t                k7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        hp7_reg  <= 49'(base6_reg) * 49'(k6_reg.scale_v);
        wp7_reg  <= 49'(base6_reg) * 49'(k6_reg.scale_h);
        b7_reg   <= b6_reg;
        cen7_reg <= cen6_reg;
        voq7_reg <= voq6_reg;
        d7_reg   <= d6_reg;
        k7_reg   <= k6_reg;
    end

    // Stage 8: saturate sizes, raw bounds.
    logic                  v8_reg, b8_reg;
    logic [14:0]           h8_reg, w8_reg;
    logic signed [15:0]    cen8_reg;
    logic signed [VQW+1:0] top8_reg, bot8_reg;
    logic signed [18:0]    lft8_reg, rgt8_reg;
    logic [32:0]           d8_reg;
    cfg_t                  k8_reg;
    logic [40:0]           hs, ws;
    logic [14:0]           hsat, wsat;
    always_comb
    begin
        hs   = hp7_reg[48:8];
        ws   = wp7_reg[48:8];
        hsat = (hs > 41'd32767) ? 15'd32767 : hs[14:0];
        wsat = (ws > 41'd32767) ? 15'd32767 : ws[14:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        h8_reg   <= hsat;
        w8_reg   <= wsat;
        top8_reg <= (VQW+2)'(k7_reg.height[12:1]) - (VQW+2)'(hsat[14:1])
                    + (VQW+2)'(voq7_reg);
        bot8_reg <= (VQW+2)'(k7_reg.height[12:1]) + (VQW+2)'(hsat[14:1])
                    + (VQW+2)'(voq7_reg);
        lft8_reg <= 19'(cen7_reg) - 19'(wsat[14:1]);
        rgt8_reg <= 19'(cen7_reg) + 19'(wsat[14:1]);
        b8_reg   <= b7_reg;
        cen8_reg <= cen7_reg;
        d8_reg   <= d7_reg;
        k8_reg   <= k7_reg;
    end

    // Stage 9: clamp and output register. Bounds can go negative, so compare signed.
    logic signed [VQW+1:0] bot_c;
    logic signed [18:0]    rgt_c;
    always_comb
    begin
        bot_c = (bot8_reg >= $signed((VQW+2)'(k8_reg.height)))
                ? $signed((VQW+2)'(k8_reg.height)) - (VQW+2)'(1) : bot8_reg;
        rgt_c = (rgt8_reg >= $signed(19'(k8_reg.width)))
                ? $signed(19'(k8_reg.width)) - 19'sd1 : rgt8_reg;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v8_reg;
    end
    always_ff @(posedge clk)
    begin
        distance_squared <= d8_reg;
        behind_viewer    <= b8_reg;
        centre_column    <= b8_reg ? 16'sd0 : cen8_reg;
        sprite_height    <= b8_reg ? 15'd0 : h8_reg;
        sprite_width     <= b8_reg ? 15'd0 : w8_reg;
        top_row   <= b8_reg ? 15'd0 : (top8_reg < 0) ? 15'd0
                     : (top8_reg > 32767) ? 15'd32767 : top8_reg[14:0];
        left_column <= b8_reg ? 15'd0 : (lft8_reg < 0) ? 15'd0
                     : (lft8_reg > 32767) ? 15'd32767 : lft8_reg[14:0];
        bottom_row <= b8_reg ? 16'sd0 : (bot_c < -32768) ? -16'sd32768 : bot_c[15:0];
        right_column <= b8_reg ? 16'sd0 : (rgt_c < -32768) ? -16'sd32768 : rgt_c[15:0];
    end

    // The three divider chains must stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dv == bv_unused && dv == vv_unused) else $error("divider chains out of step");
    a_tag_match: assert property (@(posedge clk) disable iff (!rst_n)
        dv |-> (t_b == tag_out && t_v == tag_out)) else $error("divider tags differ");
    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && behind_viewer) |-> (sprite_width == 15'd0 && sprite_height == 15'd0))
        else $error("sizes not zeroed behind viewer");
endmodule

### design/bsp_divider.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned.
module bsp_divider
    import bsp_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 34,
    parameter int TW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] out_tag
);
    logic [NW:0]    v_reg;
    logic [DW:0]    rem_reg [NW+1];
    logic [NW-1:0]  q_reg   [NW+1];
    logic [NW-1:0]  n_reg   [NW+1];
    logic [DW-1:0]  d_reg   [NW+1];
    logic [TW-1:0]  t_reg   [NW+1];

    always_comb
    begin
        v_reg[0]   = in_valid;
        rem_reg[0] = '0;
        q_reg[0]   = '0;
        n_reg[0]   = num;
        d_reg[0]   = den;
        t_reg[0]   = tag;
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DW:0] shifted, diff;
        logic        fits;
        always_comb
        begin
            shifted = {rem_reg[i][DW-1:0], n_reg[i][NW-1-i]};
            diff    = shifted - {1'b0, d_reg[i]};
            fits    = shifted >= {1'b0, d_reg[i]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= fits ? diff : shifted;
            q_reg[i+1]   <= {q_reg[i][NW-2:0], fits};
            n_reg[i+1]   <= n_reg[i];
            d_reg[i+1]   <= d_reg[i];
            t_reg[i+1]   <= t_reg[i];
        end
    end

    assign out_valid = v_reg[NW];
    assign quo       = q_reg[NW];
    assign out_tag   = t_reg[NW];
endmodule
